FILE: rtl/core/ret_pkg.sv
`default_nettype none

package ret_pkg;

	// Number of ring slots. One slot always stays free, so DEPTH-1 entries are held.
	localparam int unsigned DEPTH = 256;
	localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam logic [15:0] REP_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		op_t         operation;
		logic [15:0] segment;
		logic [31:0] offset;
		logic [7:0]  age;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] entry_segment;
		logic [31:0] entry_offset;
		logic [15:0] repeat_count;
		logic [7:0]  entry_count;
	} res_t;

	typedef struct packed {
		logic [15:0] segment;
		logic [31:0] offset;
		logic [15:0] repeat_count;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// Next slot around the ring.
	function automatic ptr_t ptr_inc(ptr_t p);
		ptr_t r;
		if (32'(p) == DEPTH - 1) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// Number of held entries, (next - oldest) mod DEPTH.
	function automatic logic [PTR_W:0] held(ptr_t next, ptr_t oldest);
		logic [PTR_W:0] d;
		d = {1'b0, next} + PTR_W'(0) - {1'b0, oldest};
		if (next < oldest) begin
			d = {1'b0, next} + (PTR_W+1)'(DEPTH) - {1'b0, oldest};
		end
		return d;
	endfunction

	// Slot of the entry of a given age, valid when age is below the held count.
	function automatic ptr_t slot_of_age(ptr_t next, logic [7:0] age);
		logic [31:0] s;
		s = 32'(next) + DEPTH - 32'd1 - 32'(age);
		if (s >= DEPTH) begin
			s = s - DEPTH;
		end
		return s[PTR_W-1:0];
	endfunction

	// Count as reported, saturated to eight bits.
	function automatic logic [7:0] sat_count(logic [PTR_W:0] c);
		logic [31:0] w;
		w = 32'(c);
		return (w > 32'd255) ? 8'hFF : w[7:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ret_ram.sv
`default_nettype none

module ret_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rle_execution_trace_buffer_unit.sv
`default_nettype none

// Execution trail recorder with repeat compression. Each request carries an
// operation: record stores a segment:offset address in a ring of DEPTH slots
// (a repeat of the newest address only bumps that entry's saturating repeat
// count), read returns the entry of a given age with 0 being the newest, and
// clear empties the ring. Every request, including the unused operation code,
// produces exactly one result whose entry_count is the number of held entries
// after that request; at most DEPTH-1 entries are held and the oldest one is
// dropped when the ring is full. Requests are taken one per clock cycle with
// no gaps as long as results are taken as they come; a stalled result holds
// the input back once the stage behind the RAM is full as well. Each result
// passes through the registered read of the trail RAM and then through the
// output register. The newest entry is mirrored in flip-flops so that
// back-to-back records of the same address compare without waiting on the
// RAM. The RAM needs no clearing after reset because only entries that were
// written are ever read.
module rle_execution_trace_buffer_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ret_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_stall,
	output ret_pkg::res_t      res
);

	import ret_pkg::*;

	// Ring pointers and the mirrored newest entry.
	ptr_t        next_q;
	ptr_t        oldest_q;
	logic [15:0] newest_seg_q;
	logic [31:0] newest_off_q;
	logic [15:0] newest_rep_q;

	// Stage 1: request has been processed, RAM read data is arriving.
	logic        valid_s1;
	logic        hit_s1;
	logic [7:0]  count_s1;

	// Output register.
	logic        out_valid_q;
	res_t        out_q;

	logic        accept;
	logic        advance;
	logic [PTR_W:0] cnt_now;
	logic        is_repeat;
	ptr_t        last_slot;
	ptr_t        next_inc;
	ptr_t        next_d;
	ptr_t        oldest_d;
	logic [PTR_W:0] cnt_after;
	logic        read_hit;
	logic        ram_we;
	ptr_t        ram_waddr;
	entry_t      ram_wdata;
	logic [15:0] rep_inc;
	entry_t      ram_rdata;

	// Stage 1 moves on when the output register is free or is being taken.
	assign advance   = valid_s1 && (!out_valid_q || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	assign cnt_now   = held(next_q, oldest_q);
	assign last_slot = slot_of_age(next_q, 8'd0);
	assign next_inc  = ptr_inc(next_q);
	assign rep_inc   = (newest_rep_q == REP_MAX) ? REP_MAX : newest_rep_q + 16'd1;
	// A record never matches against an empty ring.
	assign is_repeat = (cnt_now != '0) && (newest_seg_q == req.segment) &&
		(newest_off_q == req.offset);
	assign read_hit  = ({{(32-PTR_W-1){1'b0}}, cnt_now} > 32'(req.age));

	always_comb begin
		next_d    = next_q;
		oldest_d  = oldest_q;
		ram_we    = 1'b0;
		ram_waddr = next_q;
		ram_wdata = '{segment: req.segment, offset: req.offset, repeat_count: 16'd0};
		unique case (req.operation)
			OP_RECORD: begin
				ram_we = 1'b1;
				if (is_repeat) begin
					ram_waddr = last_slot;
					ram_wdata.repeat_count = rep_inc;
				end else begin
					next_d = next_inc;
					if (next_inc == oldest_q) begin
						oldest_d = ptr_inc(oldest_q);
					end
				end
			end
			OP_CLEAR: begin
				next_d   = '0;
				oldest_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign cnt_after = held(next_d, oldest_d);

	ret_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_trail (
		.clk   (clk),
		.we    (accept && ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept && (req.operation == OP_READ) && read_hit),
		.raddr (slot_of_age(next_q, req.age)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q      <= '0;
			oldest_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				next_q   <= next_d;
				oldest_q <= oldest_d;
			end
			valid_s1    <= accept || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && res_stall);
		end
	end

	// The newest entry mirror follows every record write; it is only trusted
	// while the ring holds at least one entry.
	always_ff @(posedge clk) begin
		if (accept && ram_we) begin
			newest_seg_q <= ram_wdata.segment;
			newest_off_q <= ram_wdata.offset;
			newest_rep_q <= ram_wdata.repeat_count;
		end
		if (accept) begin
			hit_s1   <= (req.operation == OP_READ) && read_hit;
			count_s1 <= sat_count(cnt_after);
		end
		if (advance) begin
			out_q.hit           <= hit_s1;
			out_q.entry_segment <= hit_s1 ? ram_rdata.segment : 16'd0;
			out_q.entry_offset  <= hit_s1 ? ram_rdata.offset : 32'd0;
			out_q.repeat_count  <= hit_s1 ? ram_rdata.repeat_count : 16'd0;
			out_q.entry_count   <= count_s1;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

`default_nettype wire

FILE: sim/tb_rle_execution_trace_buffer_unit.sv
`timescale 1ns / 1ps

// Testbench for the execution trail recorder. Requests go in through a
// valid/stall channel, results come back through another. Every accepted
// request is run through a behavioral copy of the trail kept here, and the
// result it should produce is queued. Results are compared field by field
// against the oldest queued result.
module tb_rle_execution_trace_buffer_unit;
	import ret_pkg::*;

	// The block ignores operation code 3, but it still answers it.
	localparam op_t OP_SPARE = op_t'(2'b11);
	localparam int unsigned SLOTS = DEPTH;
	localparam int unsigned RANDOM_PER_PHASE = 190;
	localparam int unsigned FILL_RECORDS = 256;
	localparam int unsigned REPEAT_RECORDS = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	rle_execution_trace_buffer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One row of the directed part. When typed is set, want holds the result
	// written out by hand; otherwise the trail copy below decides it.
	typedef struct {
		req_t rq;
		bit   typed;
		res_t want;
	} plan_row_t;

	// Behavioral copy of the trail: one ring of slots plus the slot that the
	// next new entry goes to and the slot of the oldest held entry.
	logic [15:0] ring_seg [SLOTS];
	logic [31:0] ring_off [SLOTS];
	logic [15:0] ring_rep [SLOTS];
	int unsigned fill_slot = 0;
	int unsigned first_slot = 0;

	res_t pending_results [$];
	int unsigned error_count = 0;

	// How often each side holds back, in percent of cycles.
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Newest address that the random stimulus recorded, so that repeats of
	// it can be produced on purpose.
	logic [15:0] last_seg = '0;
	logic [31:0] last_off = '0;

	function automatic res_t res_of(bit h, logic [15:0] sg, logic [31:0] of,
			logic [15:0] rp, logic [7:0] cnt);
		res_t r;
		r.hit = h;
		r.entry_segment = sg;
		r.entry_offset = of;
		r.repeat_count = rp;
		r.entry_count = cnt;
		return r;
	endfunction

	function automatic plan_row_t row(op_t op, logic [15:0] sg, logic [31:0] of,
			logic [7:0] ag, bit typed, res_t want);
		plan_row_t r;
		r.rq.operation = op;
		r.rq.segment = sg;
		r.rq.offset = of;
		r.rq.age = ag;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// Applies one request to the trail copy and gives the result it causes.
	task automatic trace_step(input req_t rq, output res_t rs);
		int unsigned held_n;
		int unsigned last;
		int unsigned slot;
		rs = '0;
		held_n = (fill_slot + SLOTS - first_slot) % SLOTS;
		case (rq.operation)
			OP_RECORD: begin
				last = (fill_slot + SLOTS - 1) % SLOTS;
				// An empty ring never compares against what a slot held before the clear.
				if (held_n != 0 && ring_seg[last] == rq.segment
						&& ring_off[last] == rq.offset) begin
					if (ring_rep[last] != REP_MAX) begin
						ring_rep[last] = ring_rep[last] + 16'd1;
					end
				end else begin
					ring_seg[fill_slot] = rq.segment;
					ring_off[fill_slot] = rq.offset;
					ring_rep[fill_slot] = '0;
					fill_slot = (fill_slot + 1) % SLOTS;
					// A full ring drops its oldest entry, so one slot stays free.
					if (fill_slot == first_slot) begin
						first_slot = (first_slot + 1) % SLOTS;
					end
				end
			end
			OP_READ: begin
				if (rq.age < held_n) begin
					slot = (fill_slot + 2 * SLOTS - 1 - rq.age) % SLOTS;
					rs.hit = 1'b1;
					rs.entry_segment = ring_seg[slot];
					rs.entry_offset = ring_off[slot];
					rs.repeat_count = ring_rep[slot];
				end
			end
			OP_CLEAR: begin
				fill_slot = 0;
				first_slot = 0;
			end
			default: begin
			end
		endcase
		held_n = (fill_slot + SLOTS - first_slot) % SLOTS;
		rs.entry_count = (held_n > 255) ? 8'hFF : held_n[7:0];
	endtask

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
		end
	endtask

	// Results are taken at the same edges that the block sees, with values from
	// before the edge, so the order of processes within a step does not matter.
	always @(posedge clk) begin
		res_t want;
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result %0h with no request pending", res));
			end else begin
				want = pending_results.pop_front();
				check_field("hit", 32'(res.hit), 32'(want.hit));
				check_field("entry_segment", 32'(res.entry_segment),
					32'(want.entry_segment));
				check_field("entry_offset", res.entry_offset, want.entry_offset);
				check_field("repeat_count", 32'(res.repeat_count),
					32'(want.repeat_count));
				check_field("entry_count", 32'(res.entry_count), 32'(want.entry_count));
			end
		end
	end

	// Offers one request and holds it until the block takes it. The expected
	// result is queued at the edge of acceptance. Afterwards the sender may
	// stay idle for a while; valid only drops when at least one edge follows,
	// so it is never lowered and raised within the same step.
	task automatic send_request(input req_t rq, input bit typed = 1'b0,
			input res_t want = '0);
		res_t predicted;
		req_valid <= 1'b1;
		req <= rq;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		trace_step(rq, predicted);
		pending_results.push_back(typed ? want : predicted);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Holds the sender back until every queued result has come out.
	task automatic drain_results();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_results.size() != 0);
	endtask

	// Random requests: mostly records and reads, now and then a clear or the
	// unused code. Records often repeat the newest address or come from a tiny
	// pool, so repeat counts climb; reads aim at both ends of the age range.
	function automatic req_t random_request();
		req_t rq;
		int unsigned pick;
		rq.segment = 16'($urandom);
		rq.offset = $urandom;
		rq.age = 8'($urandom);
		pick = $urandom_range(0, 199);
		if (pick == 0) begin
			rq.operation = OP_CLEAR;
		end else if (pick <= 3) begin
			rq.operation = OP_SPARE;
		end else if (pick <= 119) begin
			rq.operation = OP_RECORD;
			case ($urandom_range(0, 3))
				0: begin
					rq.segment = last_seg;
					rq.offset = last_off;
				end
				1: begin
					rq.segment = 16'($urandom_range(0, 3));
					rq.offset = $urandom_range(0, 3);
				end
				default: begin
				end
			endcase
			last_seg = rq.segment;
			last_off = rq.offset;
		end else begin
			rq.operation = OP_READ;
			case ($urandom_range(0, 2))
				0: rq.age = 8'($urandom_range(0, 7));
				1: rq.age = 8'($urandom_range(248, 255));
				default: begin
				end
			endcase
		end
		return rq;
	endfunction

	initial begin
		plan_row_t directed_plan [$];
		req_t rq;
		int unsigned sender_pcts [4];
		int unsigned recv_pcts [4];

		sender_pcts = '{0, 78, 0, 12};
		recv_pcts = '{0, 0, 78, 12};

		// Directed part. Counts in the comments are the entries held afterwards.
		// Reads and the other codes on the empty ring after reset: all misses.
		directed_plan.push_back(row(OP_READ, '0, '0, 8'd0, 1, res_of(0, 0, 0, 0, 0)));
		directed_plan.push_back(row(OP_READ, '1, '1, 8'hFF, 1, res_of(0, 0, 0, 0, 0)));
		directed_plan.push_back(row(OP_CLEAR, '1, '1, 8'hFF, 1, res_of(0, 0, 0, 0, 0)));
		directed_plan.push_back(row(OP_SPARE, '1, '1, 8'hFF, 1, res_of(0, 0, 0, 0, 0)));
		// The all-ones address twice: one entry with one repeat.
		directed_plan.push_back(row(OP_RECORD, '1, '1, 8'h00, 1, res_of(0, 0, 0, 0, 1)));
		directed_plan.push_back(row(OP_RECORD, '1, '1, 8'hFF, 1, res_of(0, 0, 0, 0, 1)));
		directed_plan.push_back(row(OP_READ, '0, '0, 8'd0, 1,
			res_of(1, 16'hFFFF, 32'hFFFF_FFFF, 16'd1, 1)));
		directed_plan.push_back(row(OP_READ, '1, '1, 8'd1, 1, res_of(0, 0, 0, 0, 1)));
		// Addresses that match the newest one in only one half are new entries.
		directed_plan.push_back(row(OP_RECORD, '0, '0, 8'hFF, 1, res_of(0, 0, 0, 0, 2)));
		directed_plan.push_back(row(OP_RECORD, '1, '0, 8'h00, 1, res_of(0, 0, 0, 0, 3)));
		directed_plan.push_back(row(OP_RECORD, '1, '1, 8'h00, 1, res_of(0, 0, 0, 0, 4)));
		directed_plan.push_back(row(OP_READ, '0, '0, 8'd3, 1,
			res_of(1, 16'hFFFF, 32'hFFFF_FFFF, 16'd1, 4)));
		directed_plan.push_back(row(OP_READ, '1, '1, 8'd2, 1, res_of(1, 0, 0, 0, 4)));
		directed_plan.push_back(row(OP_READ, '0, '0, 8'h80, 1, res_of(0, 0, 0, 0, 4)));
		// The unused code leaves the count where it was.
		directed_plan.push_back(row(OP_SPARE, '0, '0, 8'h00, 1, res_of(0, 0, 0, 0, 4)));
		directed_plan.push_back(row(OP_RECORD, 16'h5A5A, 32'hA5A5_A5A5, 8'h55, 0, '0));
		directed_plan.push_back(row(OP_READ, 16'hA5A5, 32'h5A5A_5A5A, 8'd0, 0, '0));
		directed_plan.push_back(row(OP_CLEAR, '0, '0, 8'h00, 1, res_of(0, 0, 0, 0, 0)));
		// After a clear the old newest entry must not swallow the record.
		directed_plan.push_back(row(OP_RECORD, '1, '1, 8'h00, 1, res_of(0, 0, 0, 0, 1)));
		directed_plan.push_back(row(OP_READ, '0, '0, 8'd0, 1,
			res_of(1, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 1)));
		directed_plan.push_back(row(OP_READ, '0, '0, 8'h55, 0, '0));
		directed_plan.push_back(row(OP_READ, '0, '0, 8'hAA, 0, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			send_request(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].want);
		end

		// Repeat counting: one address recorded many times in a row.
		rq = '0;
		rq.operation = OP_CLEAR;
		send_request(rq);
		rq.operation = OP_RECORD;
		rq.segment = 16'h1234;
		rq.offset = 32'hDEAD_BEEF;
		repeat (REPEAT_RECORDS) begin
			send_request(rq);
		end
		rq.operation = OP_READ;
		rq.age = 8'd0;
		send_request(rq);
		drain_results();

		// Fill every slot so the ring wraps and drops its oldest entry, read
		// across the ages up to the far end, then clear and record the newest
		// address again: the slot behind the ring start still holds it.
		rq = '0;
		rq.operation = OP_CLEAR;
		send_request(rq);
		for (int unsigned i = 0; i < FILL_RECORDS; i++) begin
			rq.operation = OP_RECORD;
			rq.segment = 16'(i);
			rq.offset = $urandom;
			send_request(rq);
		end
		last_seg = rq.segment;
		last_off = rq.offset;
		rq.operation = OP_READ;
		for (int unsigned a = 252; a <= 255; a++) begin
			rq.age = 8'(a);
			send_request(rq);
		end
		repeat (40) begin
			rq.age = 8'($urandom);
			send_request(rq);
		end
		rq.operation = OP_CLEAR;
		send_request(rq);
		rq.operation = OP_RECORD;
		rq.segment = last_seg;
		rq.offset = last_off;
		send_request(rq);
		rq.operation = OP_READ;
		rq.age = 8'd0;
		send_request(rq);
		drain_results();

		// Random phases: no holding back, sender mostly idle, receiver mostly
		// stalling, then both now and then. The sender waits out every queued
		// result between phases.
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = sender_pcts[p];
			recv_stall_pct = recv_pcts[p];
			repeat (RANDOM_PER_PHASE) begin
				send_request(random_request());
			end
			drain_results();
		end

		sender_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_rle_execution_trace_buffer_unit: clean");
		end else begin
			$display("tb_rle_execution_trace_buffer_unit: errors");
		end
		$finish;
	end

	// Watchdog, several times the slowest correct run.
	initial begin
		#200000;
		$display("tb_rle_execution_trace_buffer_unit: errors");
		$finish;
	end

endmodule
